>>> rtl/brr_pkg.sv
// Package for the bisection root refine core: widths, accumulator limit and
// the Horner coefficient table of the fixed quintic. No dependencies.
package brr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 8;
    localparam int VAL_W     = INT_BITS + FRAC_BITS;
    localparam int TOL_W     = VAL_W - 1;
    localparam int ACC_W     = 64;
    localparam int HALF_W    = ACC_W / 2;
    localparam int MUL_A_W   = HALF_W + 1;
    localparam int MUL_P_W   = MUL_A_W + VAL_W;
    localparam int PROD_W    = ACC_W + VAL_W;
    localparam int NUM_STEPS = 5;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

    localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(64'sh4000_0000_0000_0000);
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'sd1) <<< FRAC_BITS;

    // coefficients after the leading one, scaled to Q.FRAC_BITS
    function automatic logic signed [ACC_W-1:0] brr_coef(input logic [STEP_W-1:0] step);
        logic signed [ACC_W-1:0] c;
        case (step)
            STEP_W'(0): c = -ACC_W'(64'sd3);
            STEP_W'(1): c = -ACC_W'(64'sd23);
            STEP_W'(2): c = ACC_W'(64'sd51);
            STEP_W'(3): c = ACC_W'(64'sd94);
            STEP_W'(4): c = -ACC_W'(64'sd120);
            default:    c = '0;
        endcase
        return c <<< FRAC_BITS;
    endfunction

endpackage

>>> rtl/bisection_root_refine_core.sv
// Bisection root refine core: top level with sequencer and one shared
// multiplier for the Horner evaluation. Depends on brr_pkg.
//
// Usage:
//   Slave stream carries one interval per transfer: left_end in
//   s_axis_tdata[23:0], right_end in s_axis_tdata[47:24], signed Q8.16.
//   Master stream returns the midpoint of the final interval in
//   m_axis_tdata[23:0]. cfg_wen/cfg_wdata write the stop width
//   (tolerance, LSB units, zero acts as one); the user must write it only
//   while the core is idle, as the core itself does not enforce this.
//   Each polynomial evaluation is five Horner steps, each a low half
//   multiply, high half multiply, shift/clamp and coefficient add, on
//   one 33x24 multiplier. The sign of f at the left end is kept, so
//   each halving costs one evaluation plus a compare step. While the
//   core works, s_axis_tready is low. A result waits in the output
//   register while the receiver stalls; the next interval is taken
//   meanwhile, and its result is held back until the register is free.
//   Reset (rst_n low, asynchronous) returns to idle, drops m_axis_tvalid
//   and sets tolerance to 7.
module bisection_root_refine_core
    import brr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [TOL_W-1:0]  cfg_wdata,       // tolerance
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [2*VAL_W-1:0] s_axis_tdata,   // left_end, right_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata     // root_estimate
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_ADD,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [TOL_W-1:0]          tol_reg, tol_next;
    logic signed [VAL_W-1:0]   a_reg, a_next;
    logic signed [VAL_W-1:0]   b_reg, b_next;
    logic signed [VAL_W-1:0]   x_reg, x_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   t_reg, t_next;
    logic signed [MUL_P_W-1:0] plo_reg, plo_next;
    logic signed [MUL_P_W-1:0] phi_reg, phi_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      eval_a_reg, eval_a_next;
    logic                      fa_neg_reg, fa_neg_next;
    logic                      fa_pos_reg, fa_pos_next;
    logic                      mv_reg, mv_next;
    logic [VAL_W-1:0]          md_reg, md_next;

    logic signed [VAL_W:0]     sum_ab;
    logic signed [VAL_W:0]     diff_ab;
    logic [VAL_W:0]            abs_w;
    logic [TOL_W-1:0]          tol_eff;
    logic signed [VAL_W-1:0]   mid;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [PROD_W-1:0]  prod_lim;
    logic signed [ACC_W:0]     add_sum;
    logic signed [ACC_W:0]     add_lim;
    logic signed [ACC_W-1:0]   add_res;
    logic                      res_neg;
    logic                      res_pos;
    logic                      replace_a;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    always_comb
    begin
        sum_ab  = {a_reg[VAL_W-1], a_reg} + {b_reg[VAL_W-1], b_reg};
        diff_ab = {b_reg[VAL_W-1], b_reg} - {a_reg[VAL_W-1], a_reg};
        abs_w   = diff_ab[VAL_W] ? unsigned'(-diff_ab) : unsigned'(diff_ab);
        tol_eff = (tol_reg == '0) ? TOL_W'(1) : tol_reg;
        mid     = sum_ab[VAL_W:1];

        // shared multiplier: unsigned low half or signed high half of acc
        if (state_reg == ST_MUL_LO)
            mul_a = {1'b0, acc_reg[HALF_W-1:0]};
        else
            mul_a = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:HALF_W]};
        mul_p = mul_a * x_reg;

        prod     = (PROD_W'(phi_reg) <<< HALF_W) + PROD_W'(plo_reg);
        prod_sh  = prod >>> FRAC_BITS;
        prod_lim = PROD_W'(ACC_LIM);

        add_sum = (ACC_W+1)'(t_reg) + (ACC_W+1)'(brr_coef(step_reg));
        add_lim = (ACC_W+1)'(ACC_LIM);
        if (add_sum > add_lim)
            add_res = ACC_LIM;
        else if (add_sum < -add_lim)
            add_res = -ACC_LIM;
        else
            add_res = add_sum[ACC_W-1:0];
        res_neg   = add_res[ACC_W-1];
        res_pos   = !add_res[ACC_W-1] && (add_res != '0);
        replace_a = res_neg ? fa_neg_reg : fa_pos_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        tol_next    = cfg_wen ? cfg_wdata : tol_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        step_next   = step_reg;
        eval_a_next = eval_a_reg;
        fa_neg_next = fa_neg_reg;
        fa_pos_next = fa_pos_reg;
        mv_next     = mv_reg && !m_axis_tready;
        md_next     = md_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next      = s_axis_tdata[VAL_W-1:0];
                    b_next      = s_axis_tdata[2*VAL_W-1:VAL_W];
                    x_next      = s_axis_tdata[VAL_W-1:0];
                    acc_next    = ACC_ONE;
                    step_next   = '0;
                    eval_a_next = 1'b1;
                    state_next  = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                plo_next   = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                phi_next   = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (prod_sh > prod_lim)
                    t_next = ACC_LIM;
                else if (prod_sh < -prod_lim)
                    t_next = -ACC_LIM;
                else
                    t_next = prod_sh[ACC_W-1:0];
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = add_res;
                if (step_reg == STEP_W'(NUM_STEPS - 1))
                begin
                    state_next = ST_CHECK;
                    if (eval_a_reg || replace_a)
                    begin
                        fa_neg_next = res_neg;
                        fa_pos_next = res_pos;
                    end
                    if (!eval_a_reg)
                    begin
                        if (replace_a)
                            a_next = x_reg;
                        else
                            b_next = x_reg;
                    end
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_MUL_LO;
                end
            end
            ST_CHECK:
            begin
                if (abs_w <= (VAL_W+1)'(tol_eff))
                    state_next = ST_OUT;
                else
                begin
                    x_next      = mid;
                    acc_next    = ACC_ONE;
                    step_next   = '0;
                    eval_a_next = 1'b0;
                    state_next  = ST_MUL_LO;
                end
            end
            ST_OUT:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = mid;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tol_reg    <= TOL_RESET;
            mv_reg     <= 1'b0;
            step_reg   <= '0;
            eval_a_reg <= 1'b0;
            fa_neg_reg <= 1'b0;
            fa_pos_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tol_reg    <= tol_next;
            mv_reg     <= mv_next;
            step_reg   <= step_next;
            eval_a_reg <= eval_a_next;
            fa_neg_reg <= fa_neg_next;
            fa_pos_reg <= fa_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        md_reg  <= md_next;
    end

endmodule

>>> rtl/brr_checker.sv
// Port-level checker for bisection_root_refine_core, attached by bind.
// Depends on brr_pkg.
module brr_checker
    import brr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [VAL_W-1:0]   m_axis_tdata
);

    // busy after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // no result can appear right after an input transfer
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result without computation");

    // a new result comes with the return to idle
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result while still busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind bisection_root_refine_core brr_checker u_brr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb_bisection_root_refine_core.sv
// Testbench for bisection_root_refine_core: drives intervals and tolerance
// writes, predicts each root estimate and checks the master stream in order.
// Depends on rtl/brr_pkg.sv and rtl/bisection_root_refine_core.sv.
`timescale 1ns / 100ps

module tb_bisection_root_refine_core;
    import brr_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 600;
    localparam int PHASE_ITEMS = 100;
    localparam int ONE         = 1 << FRAC_BITS;

    class root_ledger;
        logic [TOL_W-1:0] stop_width;
        logic [VAL_W-1:0] roots_due[$];
        int               errors;
        longint           horner_coef[NUM_STEPS];

        function new();
            stop_width  = TOL_RESET;
            errors      = 0;
            horner_coef = '{-3, -23, 51, 94, -120};
        endfunction

        // sign of the quintic at x, Horner in Q.FRAC_BITS with floor shifts
        function int quintic_sign(logic signed [VAL_W-1:0] x);
            logic signed [95:0] acc;
            logic signed [95:0] lim;
            lim = 96'(ACC_LIM);
            acc = 96'sd1 <<< FRAC_BITS;
            for (int i = 0; i < NUM_STEPS; i++)
            begin
                acc = (acc * x) >>> FRAC_BITS;
                if (acc > lim) acc = lim;
                if (acc < -lim) acc = -lim;
                acc = acc + (96'(horner_coef[i]) <<< FRAC_BITS);
                if (acc > lim) acc = lim;
                if (acc < -lim) acc = -lim;
            end
            return (acc < 0) ? -1 : ((acc > 0) ? 1 : 0);
        endfunction

        function logic [VAL_W-1:0] bisect_root(logic signed [VAL_W-1:0] left_end,
                                               logic signed [VAL_W-1:0] right_end);
            longint a;
            longint b;
            longint w;
            longint s;
            longint stop;
            int     fs;
            int     fa;
            a    = longint'(left_end);
            b    = longint'(right_end);
            stop = (stop_width == '0) ? 64'sd1 : longint'(stop_width);
            w    = (b > a) ? b - a : a - b;
            while (w > stop)
            begin
                s  = (a + b) >>> 1;
                fs = quintic_sign(s[VAL_W-1:0]);
                fa = quintic_sign(a[VAL_W-1:0]);
                if (fs < 0)
                begin
                    if (fa < 0) a = s; else b = s;
                end
                else
                begin
                    if (fa > 0) a = s; else b = s;
                end
                w = (b > a) ? b - a : a - b;
            end
            s = (a + b) >>> 1;
            return s[VAL_W-1:0];
        endfunction

        function void note_interval(logic signed [VAL_W-1:0] left_end,
                                    logic signed [VAL_W-1:0] right_end);
            roots_due.push_back(bisect_root(left_end, right_end));
        endfunction

        function void check_root(logic [VAL_W-1:0] got);
            logic [VAL_W-1:0] want;
            if (roots_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected root_estimate %h", $time, got);
            end
            else
            begin
                want = roots_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: root_estimate exp %h got %h", $time, want, got);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wen = 1'b0;
    logic [TOL_W-1:0]   cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [2*VAL_W-1:0] s_axis_tdata = '0;    // left_end, right_end
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VAL_W-1:0]   m_axis_tdata;         // root_estimate

    root_ledger ledger = new();
    int         burst_left = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    int         idle_cycles = 0;
    int         quintic_roots[5] = '{1, -2, -4, 3, 5};

    always #1 clk = ~clk;

    bisection_root_refine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // receiver: check transfers, stall in modes of random length
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_root(m_axis_tdata);
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 39) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_interval(input logic signed [VAL_W-1:0] a,
                                 input logic signed [VAL_W-1:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        ledger.note_interval(a, b);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 7);
        end
    endtask

    task automatic drain_roots();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (ledger.roots_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        drain_roots();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        ledger.stop_width = value;
    endtask

    task automatic send_random_interval();
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] t;
        int                      r;
        int                      span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                a = VAL_W'($urandom);
                b = VAL_W'($urandom);
            end
            4, 5, 6, 7:
            begin
                r    = quintic_roots[$urandom_range(0, 4)] * ONE;
                span = $urandom_range(1, 1 << 20);
                a    = VAL_W'(r - $urandom_range(0, span));
                b    = VAL_W'(r + $urandom_range(0, span));
                if ($urandom_range(0, 3) == 0)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            default:
            begin
                a = VAL_W'($urandom);
                b = VAL_W'(a + $urandom_range(0, 64) - 32);
            end
        endcase
        send_interval(a, b);
    endtask

    initial
    begin
        logic [TOL_W-1:0] phase_tol[6];
        phase_tol = '{TOL_W'(1), TOL_W'(7), TOL_W'(0), {TOL_W{1'b1}},
                      TOL_W'($urandom_range(2, 1000)), TOL_W'($urandom_range(1, 8388607))};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tolerance: extremes, reversed, exact roots, width at the stop
        send_interval(-24'sd8388608, 24'sd8388607);
        send_interval(24'sd8388607, -24'sd8388608);
        send_interval(24'sd0, 24'sd0);
        send_interval(-24'sd8388608, -24'sd8388608);
        send_interval(24'sd8388607, 24'sd8388607);
        send_interval(24'sd0, VAL_W'(2 * ONE));
        send_interval(VAL_W'(-3 * ONE), VAL_W'(-ONE));
        send_interval(VAL_W'(2 * ONE), VAL_W'(4 * ONE));
        send_interval(VAL_W'(ONE), VAL_W'(ONE + ONE / 2));
        send_interval(VAL_W'(4 * ONE + ONE / 2), VAL_W'(5 * ONE + ONE / 2));
        send_interval(VAL_W'(5 * ONE + ONE / 2), VAL_W'(4 * ONE + ONE / 2));
        send_interval(VAL_W'(-5 * ONE), VAL_W'(-3 * ONE));
        send_interval(24'sd0, 24'sd7);
        send_interval(24'sd0, 24'sd8);
        send_interval(24'sh555555, 24'shAAAAAA);

        // zero tolerance acts as one
        write_tolerance('0);
        send_interval(24'sd0, 24'sd1);
        send_interval(24'sd0, 24'sd2);
        send_interval(-24'sd8388608, 24'sd8388607);
        send_interval(VAL_W'(ONE + 3), VAL_W'(2 * ONE));

        write_tolerance({TOL_W{1'b1}});
        send_interval(-24'sd8388608, 24'sd8388607);
        send_interval(24'sd0, 24'sd8388607);
        send_interval(24'sd8388607, -24'sd8388607);

        for (int p = 0; p < 6; p++)
        begin
            write_tolerance(phase_tol[p]);
            repeat (PHASE_ITEMS)
            begin
                send_random_interval();
                if ($urandom_range(0, 49) == 0)
                    drain_roots();
            end
        end

        drain_roots();
        repeat (TAIL_CYCLES) @(posedge clk);
        ledger.errors += ledger.roots_due.size();
        if (ledger.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
